>>> rtl/core/fcrc_pkg.sv
// fcrc_pkg: shared types, constants and the bytewise crc-16 update
// for the framed command receiver. no dependencies.
package fcrc_pkg;

    localparam int FRAME_BYTES_DEF = 18;
    localparam int MODE_OFFSET_DEF = 3;

    localparam logic [15:0] CRC_POLY   = 16'h8005;
    localparam int          CFG_IDX_W  = 2;
    localparam int          CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_BYTE = 2'd0,
        REG_KEY_BYTE   = 2'd1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_CONFIRM = 2'd1,
        PH_LISTEN  = 2'd2
    } t_rx_phase;

    // msb-first crc-16, one byte per call, no reflection
    function automatic logic [15:0] crc_feed(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> rtl/core/framed_command_receiver_crc16.sv
// framed_command_receiver_crc16: frame detector, crc-16 check and mode latch.
// depends on fcrc_pkg.
//
// usage
//   input channel carries one received byte per beat (i_in_valid / o_in_stall).
//   output channel gives exactly one result beat per input beat, in order:
//   the latched mode and flags for frame end, good crc and crc error.
//   start and key bytes are set through the write port (i_cfg_we, i_cfg_index,
//   i_cfg_data) while no byte is in flight; other indexes are ignored.
// timing
//   a byte waits in the input register until the output register can take its
//   result, then the frame state and the crc are updated in one pass and the
//   result is captured in the output register at the same edge as the state.
//   one byte per cycle sustained while the result side does not stall; the
//   bytewise crc update in one pass between the input and state registers allows it.
// reset
//   synchronous, active low: both stages empty, phase idle, crc, count and
//   mode cleared, start and key bytes zero.
// stall
//   a stalled result holds; the input register still takes a byte while the
//   output waits, and the input stalls only when both stages are full.
module framed_command_receiver_crc16
    import fcrc_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF,
    parameter int MODE_OFFSET = MODE_OFFSET_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [7:0]            i_rx_byte,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [7:0]            o_mode_value,
    output logic                  o_mode_updated,
    output logic                  o_frame_done,
    output logic                  o_crc_error
);

    logic [7:0]  r_start_byte, r_key_byte;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    t_rx_phase   r_phase, n_phase;
    logic [7:0]  r_count, n_count;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_pending, n_pending;
    logic [7:0]  r_mode, n_mode;
    logic        r_out_valid;
    logic [7:0]  r_out_mode;
    logic        r_out_updated, r_out_done, r_out_error;

    logic        fire;
    logic        done, good;
    logic [15:0] crc_next;
    logic [7:0]  count_inc;

    assign fire       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !fire;

    assign crc_next  = crc_feed(r_crc, r_in_byte);
    assign count_inc = (r_count != 8'hFF) ? r_count + 8'd1 : r_count;

    // phase sequencing
    always_comb begin
        n_phase = r_phase;
        if (fire) begin
            case (r_phase)
                PH_CONFIRM: begin
                    n_phase = (r_in_byte == r_key_byte) ? PH_LISTEN : PH_IDLE;
                end
                PH_LISTEN: begin
                    n_phase = done ? PH_IDLE : PH_LISTEN;
                end
                default: begin
                    n_phase = (r_in_byte == r_start_byte) ? PH_CONFIRM : PH_IDLE;
                end
            endcase
        end
    end

    // crc, count, mode capture and result flags
    always_comb begin
        n_crc     = r_crc;
        n_count   = r_count;
        n_pending = r_pending;
        n_mode    = r_mode;
        done      = 1'b0;
        good      = 1'b0;
        case (r_phase)
            PH_CONFIRM: begin
                if (r_in_byte == r_key_byte) begin
                    n_crc   = crc_next;
                    n_count = 8'd2;
                end
            end
            PH_LISTEN: begin
                n_crc   = crc_next;
                n_count = count_inc;
                if (r_count == 8'(MODE_OFFSET)) begin
                    n_pending = r_in_byte;
                end
                if ({1'b0, count_inc} >= 9'(FRAME_BYTES)) begin
                    done = 1'b1;
                    if (crc_next == 16'h0000) begin
                        good   = 1'b1;
                        n_mode = n_pending;
                    end
                end
            end
            default: begin
                if (r_in_byte == r_start_byte) begin
                    n_crc     = crc_feed(16'h0000, r_in_byte);
                    n_count   = 8'd1;
                    n_pending = 8'h00;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= '0;
            r_key_byte   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_START_BYTE: r_start_byte <= i_cfg_data;
                REG_KEY_BYTE:   r_key_byte   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_count   <= '0;
            r_crc     <= '0;
            r_pending <= '0;
            r_mode    <= '0;
        end else begin
            r_phase <= n_phase;
            if (fire) begin
                r_count   <= n_count;
                r_crc     <= n_crc;
                r_pending <= n_pending;
                r_mode    <= n_mode;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_mode    <= n_mode;
            r_out_updated <= good;
            r_out_done    <= done;
            r_out_error   <= done && !good;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_mode_value   = r_out_mode;
    assign o_mode_updated = r_out_updated;
    assign o_frame_done   = r_out_done;
    assign o_crc_error    = r_out_error;

endmodule

>>> rtl/core/fcrc_checker.sv
// fcrc_checker: port-level checks for framed_command_receiver_crc16,
// bound into each instance of it. no package dependency.
module fcrc_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [7:0]            o_mode_value,
    input logic                  o_mode_updated,
    input logic                  o_frame_done,
    input logic                  o_crc_error
);

    // a good frame is always an ended frame
    a_updated_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_mode_updated |-> o_frame_done)
        else $error("mode update without frame end");

    // an ended frame is either good or in error, never both
    a_done_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_done |-> (o_mode_updated != o_crc_error))
        else $error("frame end flags inconsistent");

    a_error_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_crc_error |-> o_frame_done)
        else $error("crc error without frame end");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_mode_value)
            && $stable(o_mode_updated) && $stable(o_frame_done))
        else $error("stalled result beat changed");

    // the input only stalls behind a held result beat
    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stall without a held result beat");

endmodule

bind framed_command_receiver_crc16 fcrc_checker u_fcrc_checker (.*);

>>> tb/fcrc_mode_checker.sv
// fcrc_mode_checker: watches the byte and result channels of the frame receiver,
// predicts each result beat from the accepted bytes and the register writes, and
// compares in order. depends on fcrc_pkg.
module fcrc_mode_checker
    import fcrc_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF,
    parameter int MODE_OFFSET = MODE_OFFSET_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [7:0]            i_rx_byte,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [7:0]            i_mode_value,
    input  logic                  i_mode_updated,
    input  logic                  i_frame_done,
    input  logic                  i_crc_error,
    output int                    o_fail_count,
    output int                    o_pending_count
);

    typedef struct packed {
        logic [7:0] mode;
        logic       updated;
        logic       done;
        logic       error;
    } t_mode_beat;

    t_mode_beat  mode_results_due[$];
    logic [7:0]  start_val = 8'h00;
    logic [7:0]  key_val = 8'h00;
    t_rx_phase   phase = PH_IDLE;
    logic [7:0]  frame_len = 8'h00;
    logic [15:0] crc_acc = 16'h0000;
    logic [7:0]  mode_capture = 8'h00;
    logic [7:0]  mode_held = 8'h00;
    int          mismatches = 0;

    // one data bit at a time, feedback from the top bit
    function automatic logic [15:0] crc16_shift_in(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[15] ^ b[i];
            r = {r[14:0], 1'b0};
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    task predict_mode_beat(input logic [7:0] b, output t_mode_beat r);
        logic ended;
        logic good;
        ended = 1'b0;
        good = 1'b0;
        case (phase)
            PH_CONFIRM: begin
                if (b == key_val) begin
                    crc_acc = crc16_shift_in(crc_acc, b);
                    frame_len = 8'd2;
                    phase = PH_LISTEN;
                end else begin
                    // a mismatching key is dropped, not looked at as a new start
                    phase = PH_IDLE;
                end
            end
            PH_LISTEN: begin
                crc_acc = crc16_shift_in(crc_acc, b);
                if (int'(frame_len) == MODE_OFFSET) begin
                    mode_capture = b;
                end
                if (frame_len != 8'hFF) begin
                    frame_len = frame_len + 8'd1;
                end
                if (int'(frame_len) >= FRAME_BYTES) begin
                    ended = 1'b1;
                    phase = PH_IDLE;
                    if (crc_acc == 16'h0000) begin
                        good = 1'b1;
                        mode_held = mode_capture;
                    end
                end
            end
            default: begin
                phase = PH_IDLE;
                if (b == start_val) begin
                    crc_acc = crc16_shift_in(16'h0000, b);
                    frame_len = 8'd1;
                    mode_capture = 8'h00;
                    phase = PH_CONFIRM;
                end
            end
        endcase
        r.mode = mode_held;
        r.updated = good;
        r.done = ended;
        r.error = ended && !good;
    endtask

    always @(posedge i_clk) begin : watch
        t_mode_beat seen;
        t_mode_beat want;
        if (!i_rst_n) begin
            mode_results_due.delete();
            start_val = 8'h00;
            key_val = 8'h00;
            phase = PH_IDLE;
            frame_len = 8'h00;
            crc_acc = 16'h0000;
            mode_capture = 8'h00;
            mode_held = 8'h00;
        end else begin
            // result side first so a beat never meets the expectation pushed this cycle
            if (i_out_valid && !i_out_stall) begin
                seen.mode = i_mode_value;
                seen.updated = i_mode_updated;
                seen.done = i_frame_done;
                seen.error = i_crc_error;
                if (mode_results_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result beat: mode %02h upd %b done %b err %b",
                                 seen.mode, seen.updated, seen.done, seen.error);
                    end
                end else begin
                    want = mode_results_due.pop_front();
                    if (seen !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display({"result mismatch: expected mode %02h upd %b ",
                                      "done %b err %b, got mode %02h upd %b done %b err %b"},
                                     want.mode, want.updated, want.done, want.error,
                                     seen.mode, seen.updated, seen.done, seen.error);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_mode_beat(i_rx_byte, want);
                mode_results_due.push_back(want);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_START_BYTE: start_val = i_cfg_data;
                    REG_KEY_BYTE:   key_val = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_fail_count <= mismatches;
        o_pending_count <= mode_results_due.size();
    end

endmodule

>>> tb/tb_framed_command_receiver_crc16.sv
// tb_framed_command_receiver_crc16: drives bytes, register writes and result stalls
// into the frame receiver and gives the verdict from the checker's counts.
// depends on fcrc_pkg, framed_command_receiver_crc16 and fcrc_mode_checker.
module tb_framed_command_receiver_crc16;
    import fcrc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_BYTES = 225;
    localparam int HOLD_CYCLES = 120;
    localparam int RANDOM_PHASES = 8;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_B = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_START_BYTE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic [7:0]            rx_byte = 8'h00;
    logic                  rcv_stall = 1'b0;
    logic                  long_hold = 1'b0;
    wire                   out_stall = rcv_stall | long_hold;

    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_mode_value;
    logic       o_mode_updated;
    logic       o_frame_done;
    logic       o_crc_error;

    logic       burst = 1'b0;
    logic [7:0] cur_start = 8'h00;
    logic [7:0] cur_key = 8'h00;
    int         bytes_sent = 0;
    int         cycle_count = 0;
    int         fail_count;
    int         pending_count;

    always #5 clk = ~clk;

    framed_command_receiver_crc16 u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (o_in_stall),
        .i_rx_byte      (rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_mode_value   (o_mode_value),
        .o_mode_updated (o_mode_updated),
        .o_frame_done   (o_frame_done),
        .o_crc_error    (o_crc_error)
    );

    fcrc_mode_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_stall      (o_in_stall),
        .i_rx_byte       (rx_byte),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .i_mode_value    (o_mode_value),
        .i_mode_updated  (o_mode_updated),
        .i_frame_done    (o_frame_done),
        .i_crc_error     (o_crc_error),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    // used only to build frames with a zero residue
    function automatic logic [15:0] frame_crc16(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {b, 8'h00};
        repeat (8) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // entered and left at a falling edge; valid stays up across back-to-back beats
    task send_byte(input logic [7:0] b);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (o_in_stall) @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task settle();
        in_valid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task configure(input logic [7:0] s, input logic [7:0] k);
        settle();
        write_reg(REG_START_BYTE, s);
        write_reg(REG_KEY_BYTE, k);
        // writes outside the register list must leave both bytes alone
        write_reg($urandom_range(0, 1) ? IDX_SPARE_A : IDX_SPARE_B, CFG_DATA_W'($urandom));
        cur_start = s;
        cur_key = k;
    endtask

    task send_frame(input logic [7:0] mode, input bit corrupt);
        logic [7:0]  frame [FRAME_BYTES_DEF];
        logic [15:0] crc;
        int          pos;
        frame[0] = cur_start;
        frame[1] = cur_key;
        for (int i = 2; i < FRAME_BYTES_DEF - 2; i++) begin
            frame[i] = 8'($urandom);
        end
        frame[MODE_OFFSET_DEF] = mode;
        crc = 16'h0000;
        for (int i = 0; i < FRAME_BYTES_DEF - 2; i++) begin
            crc = frame_crc16(crc, frame[i]);
        end
        frame[FRAME_BYTES_DEF - 2] = crc[15:8];
        frame[FRAME_BYTES_DEF - 1] = crc[7:0];
        if (corrupt) begin
            pos = $urandom_range(2, FRAME_BYTES_DEF - 1);
            frame[pos] = frame[pos] ^ 8'($urandom_range(1, 255));
        end
        for (int i = 0; i < FRAME_BYTES_DEF; i++) begin
            send_byte(frame[i]);
        end
    endtask

    task send_unit();
        int         pick;
        logic [7:0] b;
        logic [7:0] mode;
        burst = ($urandom_range(0, 3) == 0);
        repeat ($urandom_range(0, 2)) begin
            do b = 8'($urandom); while (b == cur_start);
            send_byte(b);
        end
        pick = $urandom_range(0, 99);
        mode = 8'($urandom);
        if ($urandom_range(0, 4) == 0) begin
            mode = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        if (pick < 60) begin
            send_frame(mode, 1'b0);
        end else if (pick < 80) begin
            send_frame(mode, 1'b1);
        end else if (pick < 90) begin
            // start beat followed by a wrong key, often the start value itself
            send_byte(cur_start);
            do b = $urandom_range(0, 1) ? cur_start : 8'($urandom); while (b == cur_key);
            send_byte(b);
        end else begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
        end
    endtask

    initial begin : results_side
        int gap;
        @(posedge rst_n);
        forever begin
            gap = burst ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                rcv_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            rcv_stall <= 1'b0;
            @(posedge clk);
            while (!(o_out_valid && !out_stall)) @(posedge clk);
            @(negedge clk);
        end
    end

    // long back-pressure while the byte side keeps going, so the input stalls
    initial begin : hold_off
        wait (bytes_sent >= 400);
        @(negedge clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold <= 1'b0;
        wait (bytes_sent >= 1300);
        @(negedge clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold <= 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        logic [7:0] s;
        logic [7:0] k;
        int         target;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        configure(8'hA5, 8'h5A);
        send_byte(8'h00);
        send_byte(8'hFF);
        // start, then the start value again in place of the key: back to idle
        send_byte(8'hA5);
        send_byte(8'hA5);
        send_byte(8'h5A);
        send_frame(8'hFF, 1'b0);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin s = 8'h00; k = 8'h00; end
                1: begin s = 8'hFF; k = 8'hFF; end
                2: begin s = 8'h00; k = 8'hFF; end
                3: begin s = 8'hFF; k = 8'h00; end
                4: begin s = 8'($urandom); k = s; end
                default: begin s = 8'($urandom); k = 8'($urandom); end
            endcase
            configure(s, k);
            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target) send_unit();
        end

        burst = 1'b0;
        settle();
        if (fail_count == 0 && pending_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/fcrc_pkg.sv
rtl/core/framed_command_receiver_crc16.sv
rtl/core/fcrc_checker.sv
tb/fcrc_mode_checker.sv
tb/tb_framed_command_receiver_crc16.sv
